### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, item kinds, character codes and the word structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int KIND_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;
	localparam int DATA_W  = 16;
	localparam int COLOR_W = 8;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

	localparam int TAB_SPACES = 4;
	localparam int TAB_W      = $clog2(TAB_SPACES);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [DATA_W-1:0] cell_data;
	} result_t;

endpackage

### hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine: cursor and screen memory sequencer
// Runs reset zeroing, put, scroll, clear and read over the cell RAM.
// ----------------------------------------------------------------------------
module tcw_engine #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [tcw_pkg::COLOR_W-1:0]     color,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tcw_pkg::item_t                  item,
	output logic                            res_valid,
	input  logic                            res_ready,
	output tcw_pkg::result_t                res
);
	import tcw_pkg::*;

	localparam int NCELLS = ROWS * COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int RW     = $clog2(ROWS + 1);
	localparam int CW     = $clog2(COLS);
	localparam int LW     = $clog2(NCELLS + 1);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PUT   = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_BLANK = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;
	localparam logic [2:0] ST_READ  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]        state_q;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [AW-1:0]     ptr_q;
	logic [CHAR_W-1:0] ch_q;
	logic              is_nl_q;
	logic              is_print_q;
	logic [TAB_W-1:0]  tab_left_q;
	logic [AW-1:0]     idx_q;
	logic              rd_ok_q;

	// write stage: every RAM write issues in the cycle after its state
	logic              we_s1;
	logic              use_rd_s1;
	logic [AW-1:0]     waddr_s1;
	logic [DATA_W-1:0] wdata_s1;

	logic              dispatch;
	logic [LW-1:0]     lin;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] ram_wdata;
	logic              is_tab;
	logic [DATA_W-1:0] low_attr;

	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_DONE) && res_ready);
	assign dispatch  = in_valid && in_ready;
	assign res_valid = (state_q == ST_DONE);

	assign lin = LW'(row_q) * LW'(COLS) + LW'(col_q);
	assign res.cursor_pos = POS_W'(lin);
	assign res.cell_data  = rd_ok_q ? ram_rdata : '0;

	assign is_tab   = (item.char_code == CH_TAB);
	assign low_attr = {4'b0000, color[3:0], 8'h00};

	assign ram_re    = (state_q == ST_READ) || (state_q == ST_COPY);
	assign ram_raddr = (state_q == ST_READ) ? idx_q : ptr_q + AW'(COLS);
	assign ram_wdata = use_rd_s1 ? ram_rdata : wdata_s1;

	tcw_ram #(
		.WIDTH(DATA_W),
		.DEPTH(NCELLS)
	) u_cells (
		.clk  (clk),
		.we   (we_s1),
		.waddr(waddr_s1),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			row_q     <= '0;
			col_q     <= '0;
			ptr_q     <= '0;
			we_s1     <= 1'b0;
			use_rd_s1 <= 1'b0;
		end else begin
			we_s1     <= 1'b0;
			use_rd_s1 <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					we_s1    <= 1'b1;
					waddr_s1 <= ptr_q;
					wdata_s1 <= '0;
					if (ptr_q == AW'(NCELLS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE, ST_DONE: begin
					if (dispatch) begin
						ch_q       <= is_tab ? CH_SPACE : item.char_code;
						is_nl_q    <= (item.char_code == CH_NEWLINE);
						is_print_q <= is_tab || ((item.char_code >= CH_SPACE) &&
							(item.char_code <= CH_PRINT_HI));
						tab_left_q <= is_tab ? TAB_W'(TAB_SPACES - 1) : '0;
						idx_q      <= AW'(item.cell_index);
						rd_ok_q    <= (item.kind == KIND_READ) &&
							(32'(item.cell_index) < 32'(NCELLS));
						ptr_q      <= '0;
						unique case (item.kind)
							KIND_PUT:   state_q <= ST_PUT;
							KIND_CLEAR: state_q <= ST_CLEAR;
							KIND_READ:  state_q <= ST_READ;
							default:    state_q <= ST_DONE;
						endcase
					end else if (state_q == ST_DONE && res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PUT: begin
					if (row_q == RW'(ROWS)) begin
						// cursor below the grid: scroll first, then retry
						ptr_q   <= '0;
						state_q <= ST_COPY;
					end else if (is_nl_q) begin
						col_q   <= '0;
						row_q   <= row_q + 1'b1;
						state_q <= ST_DONE;
					end else if (is_print_q) begin
						we_s1    <= 1'b1;
						waddr_s1 <= AW'(lin);
						wdata_s1 <= low_attr | DATA_W'(ch_q);
						if (col_q == CW'(COLS - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						if (tab_left_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							tab_left_q <= tab_left_q - 1'b1;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_COPY: begin
					// read cell ptr+COLS now, write it to ptr next cycle
					we_s1     <= 1'b1;
					use_rd_s1 <= 1'b1;
					waddr_s1  <= ptr_q;
					if (ptr_q == AW'(NCELLS - COLS - 1)) begin
						ptr_q   <= AW'(NCELLS - COLS);
						state_q <= ST_BLANK;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_BLANK: begin
					we_s1    <= 1'b1;
					waddr_s1 <= ptr_q;
					wdata_s1 <= low_attr | DATA_W'(CH_SPACE);
					if (ptr_q == AW'(NCELLS - 1)) begin
						row_q   <= row_q - 1'b1;
						state_q <= ST_PUT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_CLEAR: begin
					we_s1    <= 1'b1;
					waddr_s1 <= ptr_q;
					wdata_s1 <= {color, CH_SPACE};
					if (ptr_q == AW'(NCELLS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text console with cursor over a cell memory
// Put, clear and read items in, one word with cursor and cell data out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) takes a word of kind, char_code and
//   cell_index. Output channel (out_valid/out_ready) returns one word per
//   input word: cursor_pos after the item and cell_data (nonzero only for
//   reads). cfg_wr_en/cfg_wr_data load the color register at any cycle;
//   change it only while the block is idle.
//   The cell RAM has a single write port, so each word is worked on in
//   turn: a tab makes four cell writes; a put that finds the cursor below
//   the last row first scrolls (check, copy up, blank the last row); a
//   clear writes all ROWS*COLS cells.
//   After reset the block zeroes all ROWS*COLS cells, one per cycle, and
//   holds in_ready low until done.
//   A finished word waits in the output register; the next input word is
//   still taken and worked on, and the block stalls only when its next
//   result would meet a full output register.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tcw_pkg::KIND_W-1:0]    kind,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcw_pkg::POS_W-1:0]     cursor_pos,
	output logic [tcw_pkg::DATA_W-1:0]    cell_data
);
	import tcw_pkg::*;

	logic [COLOR_W-1:0] color_q;
	logic               out_valid_q;
	result_t            out_q;
	item_t              item;
	result_t            res;
	logic               res_valid;
	logic               res_ready;

	assign item.kind       = kind;
	assign item.char_code  = char_code;
	assign item.cell_index = cell_index;

	assign res_ready  = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign cursor_pos = out_q.cursor_pos;
	assign cell_data  = out_q.cell_data;

	tcw_engine #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.color    (color_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 8'd15;
		end else if (cfg_wr_en) begin
			color_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

endmodule

### bench/tcw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcw_checker: scoreboard for the text console writer
// Mirrors the cell grid, cursor and color register from the accepted words
// and checks every returned word against the oldest prediction.
// ----------------------------------------------------------------------------
module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COLOR_W-1:0] cfg_wr_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [KIND_W-1:0]  kind,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [IDX_W-1:0]   cell_index,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [POS_W-1:0]   cursor_pos,
	input  logic [DATA_W-1:0]  cell_data,
	output int                 errors,
	output int                 pending
);

	localparam int CELLS = COLS * ROWS;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd15;

	logic [DATA_W-1:0]  screen_model [CELLS];
	int                 cur_col;
	int                 cur_row;
	logic [COLOR_W-1:0] color_reg;
	result_t            cursor_words [$];
	result_t            oldest;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic void reset_model();
		int i;
		for (i = 0; i < CELLS; i++)
			screen_model[i] = '0;
		cur_col   = 0;
		cur_row   = 0;
		color_reg = COLOR_RESET;
	endfunction

	// cursor parked below the grid: shift everything up one row first
	function automatic void scroll_if_below();
		int i;
		if (cur_row < ROWS)
			return;
		for (i = 0; i < CELLS - COLS; i++)
			screen_model[i] = screen_model[i + COLS];
		for (i = CELLS - COLS; i < CELLS; i++)
			screen_model[i] = {4'h0, color_reg[3:0], CH_SPACE};
		cur_row--;
	endfunction

	function automatic void store_glyph(input logic [CHAR_W-1:0] ch);
		scroll_if_below();
		screen_model[cur_row * COLS + cur_col] = {4'h0, color_reg[3:0], ch};
		cur_col++;
		if (cur_col >= COLS) begin
			cur_col = 0;
			cur_row++;
		end
	endfunction

	function automatic result_t predict_word(input logic [KIND_W-1:0] k,
			input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx);
		result_t r;
		int      i;
		int      pos;
		r.cell_data = '0;
		case (k)
			KIND_PUT: begin
				scroll_if_below();
				if (ch == CH_NEWLINE) begin
					cur_col = 0;
					cur_row++;
				end else if (ch == CH_TAB) begin
					for (i = 0; i < TAB_SPACES; i++)
						store_glyph(CH_SPACE);
				end else if (ch >= CH_SPACE && ch <= CH_PRINT_HI) begin
					store_glyph(ch);
				end
			end
			KIND_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen_model[i] = {color_reg, CH_SPACE};
			end
			KIND_READ: begin
				if (idx < CELLS)
					r.cell_data = screen_model[idx];
			end
			default: ;
		endcase
		pos = cur_row * COLS + cur_col;
		r.cursor_pos = pos[POS_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			cursor_words.delete();
		end else begin
			if (cfg_wr_en)
				color_reg = cfg_wr_data;
			if (in_valid && in_ready)
				cursor_words.push_back(predict_word(kind, char_code, cell_index));
			if (out_valid && out_ready) begin
				if (cursor_words.size() == 0) begin
					report_mismatch("word with nothing pending", cursor_pos, 0);
				end else begin
					oldest = cursor_words.pop_front();
					if (cursor_pos !== oldest.cursor_pos)
						report_mismatch("cursor_pos", cursor_pos, oldest.cursor_pos);
					if (cell_data !== oldest.cell_data)
						report_mismatch("cell_data", cell_data, oldest.cell_data);
				end
			end
		end
		pending = cursor_words.size();
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the text console writer
// Drives put, clear, read and unused-kind words with random gaps and back-pressure,
// changes the color between phases and leaves checking to tcw_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import tcw_pkg::*;

	localparam int COLS  = 80;
	localparam int ROWS  = 25;
	localparam int CELLS = COLS * ROWS;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 85;
	localparam int TAIL_CYCLES = 50;
	// scrolls and clears under heavy stalls still fit well below this limit
	localparam int LIMIT_CYCLES = 2_000_000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [COLOR_W-1:0] cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic [KIND_W-1:0]  kind        = '0;
	logic [CHAR_W-1:0]  char_code   = '0;
	logic [IDX_W-1:0]   cell_index  = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [POS_W-1:0]   cursor_pos;
	logic [DATA_W-1:0]  cell_data;

	int fail_count;
	int pending;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	text_console_writer #(
		.COLS(COLS),
		.ROWS(ROWS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.char_code  (char_code),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_pos (cursor_pos),
		.cell_data  (cell_data)
	);

	tcw_checker #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.char_code  (char_code),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_pos (cursor_pos),
		.cell_data  (cell_data),
		.errors     (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_word(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		char_code  <= ch;
		cell_index <= idx;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic logic [CHAR_W-1:0] pick_char();
		int c;
		c = $urandom_range(99);
		if (c < 7)
			return CH_NEWLINE;
		else if (c < 12)
			return CH_TAB;
		else if (c < 22)
			return CHAR_W'($urandom_range(CH_SPACE - 1));
		else if (c < 32)
			return CHAR_W'($urandom_range(8'hFF, CH_PRINT_HI + 1));
		else
			return CHAR_W'($urandom_range(CH_PRINT_HI, CH_SPACE));
	endfunction

	task automatic send_random_word();
		int                pick;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		pick = $urandom_range(99);
		ch   = CHAR_W'($urandom_range(255));
		idx  = IDX_W'($urandom_range(2047));
		if (pick < 3) begin
			send_word(KIND_CLEAR, ch, idx);
		end else if (pick < 5) begin
			send_word(KIND_UNUSED, ch, idx);
		end else if (pick < 17) begin
			if ($urandom_range(4) != 0)
				idx = IDX_W'($urandom_range(CELLS - 1));
			send_word(KIND_READ, ch, idx);
		end else begin
			send_word(KIND_PUT, pick_char(), idx);
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int mode, input logic [COLOR_W-1:0] color);
		int sent;
		int len;
		int burst;
		send_idle_pct  = (mode == 1) ? 67 : (mode == 3) ? 14 : 0;
		recv_stall_pct = (mode == 2) ? 67 : (mode == 3) ? 14 : 0;
		// color only changes with the block drained
		wait_for_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= color;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sent = 0;
		while (sent < PHASE_WORDS) begin
			burst = $urandom_range(999);
			if (burst < 15) begin
				// run of newlines: pushes the cursor down into scrolling
				len = $urandom_range(10, 2);
				repeat (len)
					send_word(KIND_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
				sent += len;
			end else if (burst < 20) begin
				// a line of 70 to 90 printable characters, then a newline
				len = $urandom_range(90, 70);
				repeat (len)
					send_word(KIND_PUT, CHAR_W'($urandom_range(CH_PRINT_HI, CH_SPACE)),
						IDX_W'($urandom_range(2047)));
				send_word(KIND_PUT, CH_NEWLINE, IDX_W'($urandom_range(2047)));
				sent += len + 1;
			end else begin
				send_random_word();
				sent++;
			end
		end
	endtask

	initial begin
		logic [COLOR_W-1:0] colors [PHASES];
		int p;
		colors = '{8'h00, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'h00, 8'h5A, 8'hA5};
		colors[2] = COLOR_W'($urandom_range(255));
		colors[5] = COLOR_W'($urandom_range(255));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words at the reset color
		send_word(KIND_READ, 8'h00, 11'd0);
		send_word(KIND_READ, 8'hFF, IDX_W'(CELLS - 1));
		send_word(KIND_READ, 8'h00, 11'h7FF);
		send_word(KIND_PUT, 8'h41, 11'd0);
		send_word(KIND_PUT, CH_SPACE, 11'h7FF);
		send_word(KIND_PUT, CH_PRINT_HI, 11'd0);
		send_word(KIND_PUT, 8'h00, 11'd0);
		send_word(KIND_PUT, 8'h1F, 11'd0);
		send_word(KIND_PUT, 8'h80, 11'd0);
		send_word(KIND_PUT, 8'hFF, 11'd0);
		send_word(KIND_PUT, CH_TAB, 11'd0);
		send_word(KIND_PUT, CH_NEWLINE, 11'd0);
		send_word(KIND_UNUSED, 8'hFF, 11'h7FF);
		send_word(KIND_READ, 8'h00, 11'd0);
		send_word(KIND_READ, 8'h00, 11'd2);
		send_word(KIND_READ, 8'h00, 11'd6);
		send_word(KIND_CLEAR, 8'h00, 11'd0);
		send_word(KIND_READ, 8'h00, 11'd5);
		send_word(KIND_READ, 8'h00, IDX_W'(CELLS));
		send_word(KIND_PUT, 8'h7E, 11'd0);
		send_word(KIND_READ, 8'h00, IDX_W'(COLS));

		for (p = 0; p < PHASES; p++)
			run_phase(p % 4, colors[p]);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
